>>> src/dahdsr_pkg.sv
package dahdsr_pkg;

    localparam int LEN_W   = 24;
    localparam int LVL_W   = 16;
    localparam int PROG_W  = LVL_W + 1;
    localparam int STEPS   = 16;
    localparam int STEP_W  = 4;

    localparam logic [LEN_W-1:0]  LEN_MAX = {LEN_W{1'b1}};
    localparam logic [PROG_W-1:0] ONE     = PROG_W'(1) << LVL_W;
    localparam logic [LVL_W-1:0]  FULL    = {LVL_W{1'b1}};

    // floor(x / 10) = (x * DIV10_MUL) >> DIV10_SH for 24-bit x
    localparam logic [23:0] DIV10_MUL = 24'hCCCCCD;
    localparam int          DIV10_SH  = 27;
    // floor(y / 127) = (y * RECIP_127) >> RECIP_SH for y below 2^30
    localparam logic [30:0] RECIP_127 = 31'd1082196485;
    localparam int          RECIP_SH  = 37;

    localparam logic [1:0] KIND_TICK     = 2'd0;
    localparam logic [1:0] KIND_NOTE_ON  = 2'd1;
    localparam logic [1:0] KIND_NOTE_OFF = 2'd2;

    localparam logic [2:0] CFG_DELAY   = 3'd0;
    localparam logic [2:0] CFG_ATTACK  = 3'd1;
    localparam logic [2:0] CFG_HOLD    = 3'd2;
    localparam logic [2:0] CFG_DECAY   = 3'd3;
    localparam logic [2:0] CFG_RELEASE = 3'd4;
    localparam logic [2:0] CFG_SUSTAIN = 3'd5;
    localparam logic [2:0] CFG_CURVES  = 3'd6;
    localparam logic [2:0] CFG_ENABLE  = 3'd7;

    typedef enum logic [2:0] {
        ST_IDLE    = 3'd0,
        ST_DELAY   = 3'd1,
        ST_ATTACK  = 3'd2,
        ST_HOLD    = 3'd3,
        ST_DECAY   = 3'd4,
        ST_SUSTAIN = 3'd5,
        ST_RELEASE = 3'd6,
        ST_FORCED  = 3'd7
    } stage_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_NOTE_ON,
        OP_NOTE_OFF,
        OP_ZERO,
        OP_ADVANCE,
        OP_POW_INIT,
        OP_SQUARE,
        OP_SCALE,
        OP_RECIP,
        OP_EXP_STEP,
        OP_EXP_SHIFT,
        OP_LEVEL,
        OP_FINISH
    } dp_op_t;

    typedef struct packed {
        dp_op_t            op;
        logic [STEP_W-1:0] idx;
        logic              tail;
    } dp_cmd_t;

    typedef struct packed {
        logic             active;
        logic             div_busy;
        logic [LVL_W-1:0] level;
        stage_t           stage;
    } dp_status_t;

    typedef struct packed {
        logic [LEN_W-1:0] delay_len;
        logic [LEN_W-1:0] attack_len;
        logic [LEN_W-1:0] hold_len;
        logic [LEN_W-1:0] decay_len;
        logic [LEN_W-1:0] release_len;
        logic [LVL_W-1:0] sustain_level;
        logic [23:0]      curve_shapes;
        logic             enable;
    } cfg_t;

    typedef logic [STEPS-1:0][29:0] exp_tab_t;

    function automatic logic [63:0] isqrt_c(input logic [63:0] v);
        logic [63:0] n;
        logic [63:0] root;
        logic [63:0] bitv;
        int j;
        n = v;
        root = '0;
        bitv = 64'd1 << 62;
        for (j = 0; j < 32; j++) begin
            if (bitv > n) bitv = bitv >> 2;
        end
        for (j = 0; j < 32; j++) begin
            if (bitv != 0) begin
                if (n >= root + bitv) begin
                    n = n - (root + bitv);
                    root = (root >> 1) + bitv;
                end else begin
                    root = root >> 1;
                end
                bitv = bitv >> 2;
            end
        end
        return root;
    endfunction

    // factors 2^(-2^-(i+1)) in Q0.30, each the square root of the one before
    function automatic exp_tab_t build_exp_tab();
        exp_tab_t tab;
        logic [63:0] c;
        int i;
        c = 64'd1 << 29;
        for (i = 0; i < STEPS; i++) begin
            c = isqrt_c(c << 30);
            tab[i] = c[29:0];
        end
        return tab;
    endfunction

    localparam exp_tab_t EXP_TAB = build_exp_tab();

endpackage

>>> src/dahdsr_envelope_generator.sv
// DAHDSR envelope generator. Each input item is a sample tick, a note-on or a note-off
// (s_tuser selects which); every item returns one result with the envelope level in
// unsigned Q0.16 and the stage it leaves the envelope in. A new item is taken only once
// the last result is in the output register. A tick evaluates the curve through 16
// squaring steps for the log and 16 multiply steps for the power of two, one multiplier
// per step, while the progress division runs alongside in its own divider. Note events
// and ticks while disabled or idle skip the curve. The user must write registers
// through the cfg_wr port only while no item is in flight; the block does not enforce it.
module dahdsr_envelope_generator (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,      // [0] allow_tail
    input  logic [1:0]  s_tuser,      // [1:0] kind
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,      // [15:0] level, [18:16] stage
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_wr_addr,
    input  logic [23:0] cfg_wr_data
);

    dahdsr_pkg::cfg_t       cfg_reg;
    dahdsr_pkg::dp_cmd_t    cmd;
    dahdsr_pkg::dp_status_t status;
    logic                   out_load;
    logic [15:0]            level_reg;
    logic [2:0]             stage_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.delay_len     <= 24'd0;
            cfg_reg.attack_len    <= 24'd480;
            cfg_reg.hold_len      <= 24'd0;
            cfg_reg.decay_len     <= 24'd4800;
            cfg_reg.release_len   <= 24'd9600;
            cfg_reg.sustain_level <= 16'd45875;
            cfg_reg.curve_shapes  <= 24'd0;
            cfg_reg.enable        <= 1'b1;
        end else if (cfg_wr_en) begin
            unique case (cfg_wr_addr)
                dahdsr_pkg::CFG_DELAY:   cfg_reg.delay_len     <= cfg_wr_data;
                dahdsr_pkg::CFG_ATTACK:  cfg_reg.attack_len    <= cfg_wr_data;
                dahdsr_pkg::CFG_HOLD:    cfg_reg.hold_len      <= cfg_wr_data;
                dahdsr_pkg::CFG_DECAY:   cfg_reg.decay_len     <= cfg_wr_data;
                dahdsr_pkg::CFG_RELEASE: cfg_reg.release_len   <= cfg_wr_data;
                dahdsr_pkg::CFG_SUSTAIN: cfg_reg.sustain_level <= cfg_wr_data[15:0];
                dahdsr_pkg::CFG_CURVES:  cfg_reg.curve_shapes  <= cfg_wr_data;
                dahdsr_pkg::CFG_ENABLE:  cfg_reg.enable        <= cfg_wr_data[0];
                default: begin
                end
            endcase
        end
    end

    dahdsr_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_kind   (s_tuser),
        .s_tail   (s_tdata[0]),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .out_load (out_load),
        .cmd      (cmd),
        .status   (status)
    );

    dahdsr_dp u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg_reg),
        .cmd     (cmd),
        .status  (status)
    );

    always_ff @(posedge aclk) begin
        if (out_load) begin
            level_reg <= status.level;
            stage_reg <= status.stage;
        end
    end

    assign m_tdata = {5'd0, stage_reg, level_reg};

    a_idle_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        status.stage == dahdsr_pkg::ST_IDLE |-> status.level == 16'd0)
        else $error("idle stage with nonzero level");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |-> !out_load)
        else $error("result overwritten while waiting");

    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("item accepted while another is in work");

endmodule

>>> src/dahdsr_div.sv
module dahdsr_div (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            start,
    input  logic [dahdsr_pkg::LEN_W-1:0]    dividend,
    input  logic [dahdsr_pkg::LEN_W-1:0]    divisor,
    output logic                            busy,
    output logic [dahdsr_pkg::PROG_W-1:0]   quot
);

    localparam int CNT_W = $clog2(dahdsr_pkg::PROG_W + 1);

    logic [dahdsr_pkg::LEN_W:0]    rem_reg;
    logic [dahdsr_pkg::PROG_W-1:0] quot_reg;
    logic [CNT_W-1:0]              cnt_reg;
    logic                          busy_reg;
    logic                          ge;
    logic [dahdsr_pkg::LEN_W:0]    diff;
    logic [dahdsr_pkg::LEN_W:0]    rem_sel;

    // restoring division, one quotient bit per cycle, integer bit first
    assign ge      = rem_reg >= {1'b0, divisor};
    assign diff    = rem_reg - {1'b0, divisor};
    assign rem_sel = ge ? diff : rem_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            cnt_reg  <= CNT_W'(dahdsr_pkg::PROG_W);
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1)) busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg  <= {1'b0, dividend};
            quot_reg <= '0;
        end else if (busy_reg) begin
            rem_reg  <= {rem_sel[dahdsr_pkg::LEN_W-1:0], 1'b0};
            quot_reg <= {quot_reg[dahdsr_pkg::PROG_W-2:0], ge};
        end
    end

    assign busy = busy_reg;
    assign quot = quot_reg;

endmodule

>>> src/dahdsr_dp.sv
module dahdsr_dp (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  dahdsr_pkg::cfg_t       cfg,
    input  dahdsr_pkg::dp_cmd_t    cmd,
    output dahdsr_pkg::dp_status_t status
);

    localparam int LEN_W  = dahdsr_pkg::LEN_W;
    localparam int LVL_W  = dahdsr_pkg::LVL_W;
    localparam int PROG_W = dahdsr_pkg::PROG_W;

    // envelope state
    dahdsr_pkg::stage_t stage_reg, stage_next;
    logic [LEN_W-1:0]  count_reg, count_next;
    logic [LEN_W-1:0]  len_reg, len_next;
    logic [PROG_W-1:0] prog_reg, prog_next;
    logic [LVL_W-1:0]  cur_reg, cur_next;
    logic [LVL_W-1:0]  rs_reg, rs_next;

    // curve evaluation
    logic [PROG_W-1:0] x_reg, x_next;
    logic [8:0]        coef_reg, coef_next;
    logic              lin_reg, lin_next;
    logic              mir_reg, mir_next;
    logic [4:0]        k_reg, k_next;
    logic [30:0]       mant_reg, mant_next;
    logic [15:0]       fr_reg, fr_next;
    logic [29:0]       prod_reg, prod_next;
    logic [22:0]       e_reg, e_next;
    logic [30:0]       r_reg, r_next;
    logic [PROG_W-1:0] y_reg, y_next;

    logic [LEN_W-1:0]  forced_div_reg;
    logic [LEN_W-1:0]  count_inc;
    logic              div_busy;
    logic [PROG_W-1:0] div_quot;

    logic                do_enter;
    dahdsr_pkg::stage_t  enter_st;
    logic [7:0]          cbyte;
    logic [8:0]          mag;
    logic [PROG_W-1:0]   x_calc;
    logic [3:0]          lead;
    logic [61:0]         sq;
    logic [20:0]         log_l;
    logic [60:0]         recip_p;
    logic [60:0]         exp_p;
    logic [6:0]          exp_n;
    logic [PROG_W-1:0]   pw;
    logic [PROG_W-1:0]   base;
    logic [PROG_W-1:0]   ym;
    logic [LVL_W-1:0]    mul_a;
    logic [32:0]         lvl_p;
    logic [PROG_W-1:0]   q_sat;

    always_ff @(posedge aclk) begin
        forced_div_reg <= LEN_W'((48'(cfg.release_len) * 48'(dahdsr_pkg::DIV10_MUL))
                                 >> dahdsr_pkg::DIV10_SH);
    end

    assign count_inc = (count_reg == dahdsr_pkg::LEN_MAX) ? count_reg : count_reg + 1'b1;

    dahdsr_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.op == dahdsr_pkg::OP_ADVANCE),
        .dividend (count_inc),
        .divisor  (len_reg),
        .busy     (div_busy),
        .quot     (div_quot)
    );

    always_comb begin
        cbyte = cfg.curve_shapes[23:16];
        case (stage_reg)
            dahdsr_pkg::ST_ATTACK: cbyte = cfg.curve_shapes[7:0];
            dahdsr_pkg::ST_DECAY:  cbyte = cfg.curve_shapes[15:8];
            default:               cbyte = cfg.curve_shapes[23:16];
        endcase
        mag    = cbyte[7] ? 9'd256 - {1'b0, cbyte} : {1'b0, cbyte};
        x_calc = cbyte[7] ? dahdsr_pkg::ONE - prog_reg : prog_reg;
        lead   = '0;
        for (int j = 0; j < 16; j++) begin
            if (x_calc[j]) lead = 4'(j);
        end

        sq      = 62'(mant_reg) * 62'(mant_reg);
        log_l   = {k_reg, 16'd0} - 21'(fr_reg);
        recip_p = 61'(prod_reg) * 61'(dahdsr_pkg::RECIP_127);
        exp_p   = 61'(r_reg) * 61'(dahdsr_pkg::EXP_TAB[cmd.idx]);
        exp_n   = e_reg[22:16];
        pw      = (exp_n > 7'd16) ? '0 : PROG_W'(r_reg >> (5'd14 + exp_n[4:0]));
        base    = x_reg == '0 ? '0 : (x_reg[LVL_W] ? dahdsr_pkg::ONE : pw);

        ym    = dahdsr_pkg::ONE - y_reg;
        mul_a = (stage_reg == dahdsr_pkg::ST_DECAY) ? dahdsr_pkg::FULL - cfg.sustain_level
                                                    : rs_reg;
        lvl_p = 33'(mul_a) * 33'(ym);
        q_sat = (div_quot > dahdsr_pkg::ONE) ? dahdsr_pkg::ONE : div_quot;
    end

    always_comb begin
        stage_next = stage_reg;
        count_next = count_reg;
        len_next   = len_reg;
        prog_next  = prog_reg;
        cur_next   = cur_reg;
        rs_next    = rs_reg;
        x_next     = x_reg;
        coef_next  = coef_reg;
        lin_next   = lin_reg;
        mir_next   = mir_reg;
        k_next     = k_reg;
        mant_next  = mant_reg;
        fr_next    = fr_reg;
        prod_next  = prod_reg;
        e_next     = e_reg;
        r_next     = r_reg;
        y_next     = y_reg;
        do_enter   = 1'b0;
        enter_st   = dahdsr_pkg::ST_IDLE;

        unique case (cmd.op)
            dahdsr_pkg::OP_NONE: begin
            end
            dahdsr_pkg::OP_NOTE_ON: begin
                do_enter = 1'b1;
                enter_st = dahdsr_pkg::ST_DELAY;
            end
            dahdsr_pkg::OP_NOTE_OFF: begin
                if (stage_reg != dahdsr_pkg::ST_IDLE) begin
                    rs_next  = cur_reg;
                    do_enter = 1'b1;
                    enter_st = cmd.tail ? dahdsr_pkg::ST_RELEASE : dahdsr_pkg::ST_FORCED;
                end
            end
            dahdsr_pkg::OP_ZERO: begin
                cur_next = '0;
            end
            dahdsr_pkg::OP_ADVANCE: begin
                count_next = count_inc;
            end
            dahdsr_pkg::OP_POW_INIT: begin
                lin_next  = (cbyte <= 8'd1) || (cbyte == 8'hFF);
                mir_next  = cbyte[7];
                coef_next = 9'(10'd127 + 10'(mag) * 10'd3);
                x_next    = x_calc;
                k_next    = 5'd16 - 5'(lead);
                mant_next = 31'(x_calc[LVL_W-1:0]) << (5'd30 - 5'(lead));
                fr_next   = '0;
            end
            dahdsr_pkg::OP_SQUARE: begin
                // keep the mantissa in [1,2), collect one log2 bit
                if (sq[61]) begin
                    mant_next = sq[61:31];
                    fr_next   = {fr_reg[14:0], 1'b1};
                end else begin
                    mant_next = sq[60:30];
                    fr_next   = {fr_reg[14:0], 1'b0};
                end
            end
            dahdsr_pkg::OP_SCALE: begin
                prod_next = 30'(30'(log_l) * 30'(coef_reg));
            end
            dahdsr_pkg::OP_RECIP: begin
                e_next = 23'(recip_p >> dahdsr_pkg::RECIP_SH);
                r_next = 31'h4000_0000;
            end
            dahdsr_pkg::OP_EXP_STEP: begin
                if (e_reg[4'd15 - cmd.idx]) r_next = exp_p[60:30];
            end
            dahdsr_pkg::OP_EXP_SHIFT: begin
                if (lin_reg) y_next = prog_reg;
                else if (mir_reg) y_next = dahdsr_pkg::ONE - base;
                else y_next = base;
            end
            dahdsr_pkg::OP_LEVEL: begin
                case (stage_reg)
                    dahdsr_pkg::ST_ATTACK:
                        cur_next = y_reg[LVL_W] ? dahdsr_pkg::FULL : y_reg[LVL_W-1:0];
                    dahdsr_pkg::ST_HOLD:    cur_next = dahdsr_pkg::FULL;
                    dahdsr_pkg::ST_DECAY:   cur_next = cfg.sustain_level + lvl_p[31:16];
                    dahdsr_pkg::ST_SUSTAIN: cur_next = cfg.sustain_level;
                    dahdsr_pkg::ST_RELEASE, dahdsr_pkg::ST_FORCED:
                        cur_next = lvl_p[31:16];
                    default:                cur_next = '0;
                endcase
            end
            dahdsr_pkg::OP_FINISH: begin
                prog_next = (len_reg == '0) ? dahdsr_pkg::ONE : q_sat;
                if (count_reg >= len_reg) begin
                    case (stage_reg)
                        dahdsr_pkg::ST_DELAY: begin
                            do_enter = 1'b1;
                            enter_st = dahdsr_pkg::ST_ATTACK;
                        end
                        dahdsr_pkg::ST_ATTACK: begin
                            cur_next = dahdsr_pkg::FULL;
                            do_enter = 1'b1;
                            enter_st = dahdsr_pkg::ST_HOLD;
                        end
                        dahdsr_pkg::ST_HOLD: begin
                            do_enter = 1'b1;
                            enter_st = dahdsr_pkg::ST_DECAY;
                        end
                        dahdsr_pkg::ST_DECAY: begin
                            cur_next = cfg.sustain_level;
                            do_enter = 1'b1;
                            enter_st = dahdsr_pkg::ST_SUSTAIN;
                        end
                        dahdsr_pkg::ST_RELEASE, dahdsr_pkg::ST_FORCED: begin
                            cur_next = '0;
                            do_enter = 1'b1;
                            enter_st = dahdsr_pkg::ST_IDLE;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            default: begin
            end
        endcase

        if (do_enter) begin
            stage_next = enter_st;
            count_next = '0;
            prog_next  = '0;
            case (enter_st)
                dahdsr_pkg::ST_DELAY:   len_next = cfg.delay_len;
                dahdsr_pkg::ST_ATTACK:
                    len_next = (cfg.attack_len == '0) ? LEN_W'(1) : cfg.attack_len;
                dahdsr_pkg::ST_HOLD:    len_next = cfg.hold_len;
                dahdsr_pkg::ST_DECAY:
                    len_next = (cfg.decay_len == '0) ? LEN_W'(1) : cfg.decay_len;
                dahdsr_pkg::ST_RELEASE:
                    len_next = (cfg.release_len == '0) ? LEN_W'(1) : cfg.release_len;
                dahdsr_pkg::ST_FORCED:
                    len_next = (forced_div_reg == '0) ? LEN_W'(1) : forced_div_reg;
                default:                len_next = '0;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stage_reg <= dahdsr_pkg::ST_IDLE;
            count_reg <= '0;
            len_reg   <= '0;
            prog_reg  <= '0;
            cur_reg   <= '0;
            rs_reg    <= '0;
        end else begin
            stage_reg <= stage_next;
            count_reg <= count_next;
            len_reg   <= len_next;
            prog_reg  <= prog_next;
            cur_reg   <= cur_next;
            rs_reg    <= rs_next;
        end
    end

    always_ff @(posedge aclk) begin
        x_reg    <= x_next;
        coef_reg <= coef_next;
        lin_reg  <= lin_next;
        mir_reg  <= mir_next;
        k_reg    <= k_next;
        mant_reg <= mant_next;
        fr_reg   <= fr_next;
        prod_reg <= prod_next;
        e_reg    <= e_next;
        r_reg    <= r_next;
        y_reg    <= y_next;
    end

    assign status.active   = cfg.enable && (stage_reg != dahdsr_pkg::ST_IDLE);
    assign status.div_busy = div_busy;
    assign status.level    = cur_reg;
    assign status.stage    = stage_reg;

endmodule

>>> src/dahdsr_ctrl.sv
module dahdsr_ctrl (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [1:0]             s_kind,
    input  logic                   s_tail,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic                   out_load,
    output dahdsr_pkg::dp_cmd_t    cmd,
    input  dahdsr_pkg::dp_status_t status
);

    typedef enum logic [3:0] {
        S_READY,
        S_DECODE,
        S_POW_INIT,
        S_SQUARE,
        S_SCALE,
        S_RECIP,
        S_EXP,
        S_SHIFT,
        S_LEVEL,
        S_WAIT,
        S_DONE
    } state_t;

    state_t                        state_reg, state_next;
    logic [dahdsr_pkg::STEP_W-1:0] cnt_reg, cnt_next;
    logic [1:0]                    kind_reg;
    logic                          tail_reg;
    logic                          m_tvalid_reg, m_tvalid_next;
    logic                          last_step;

    assign last_step = cnt_reg == dahdsr_pkg::STEP_W'(dahdsr_pkg::STEPS - 1);

    always_comb begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        cmd.op        = dahdsr_pkg::OP_NONE;
        cmd.idx       = cnt_reg;
        cmd.tail      = tail_reg;
        out_load      = 1'b0;
        m_tvalid_next = m_tvalid_reg && !m_tready;

        unique case (state_reg)
            S_READY: begin
                if (s_tvalid) state_next = S_DECODE;
            end
            S_DECODE: begin
                state_next = S_DONE;
                unique case (kind_reg)
                    dahdsr_pkg::KIND_TICK: begin
                        if (status.active) begin
                            cmd.op     = dahdsr_pkg::OP_ADVANCE;
                            state_next = S_POW_INIT;
                        end else begin
                            cmd.op = dahdsr_pkg::OP_ZERO;
                        end
                    end
                    dahdsr_pkg::KIND_NOTE_ON:  cmd.op = dahdsr_pkg::OP_NOTE_ON;
                    dahdsr_pkg::KIND_NOTE_OFF: cmd.op = dahdsr_pkg::OP_NOTE_OFF;
                    default: begin
                    end
                endcase
            end
            S_POW_INIT: begin
                cmd.op     = dahdsr_pkg::OP_POW_INIT;
                cnt_next   = '0;
                state_next = S_SQUARE;
            end
            S_SQUARE: begin
                cmd.op   = dahdsr_pkg::OP_SQUARE;
                cnt_next = cnt_reg + 1'b1;
                if (last_step) state_next = S_SCALE;
            end
            S_SCALE: begin
                cmd.op     = dahdsr_pkg::OP_SCALE;
                state_next = S_RECIP;
            end
            S_RECIP: begin
                cmd.op     = dahdsr_pkg::OP_RECIP;
                cnt_next   = '0;
                state_next = S_EXP;
            end
            S_EXP: begin
                cmd.op   = dahdsr_pkg::OP_EXP_STEP;
                cnt_next = cnt_reg + 1'b1;
                if (last_step) state_next = S_SHIFT;
            end
            S_SHIFT: begin
                cmd.op     = dahdsr_pkg::OP_EXP_SHIFT;
                state_next = S_LEVEL;
            end
            S_LEVEL: begin
                cmd.op     = dahdsr_pkg::OP_LEVEL;
                state_next = S_WAIT;
            end
            S_WAIT: begin
                if (!status.div_busy) begin
                    cmd.op     = dahdsr_pkg::OP_FINISH;
                    state_next = S_DONE;
                end
            end
            S_DONE: begin
                // hold until the output register is free
                if (!m_tvalid_reg || m_tready) begin
                    out_load      = 1'b1;
                    m_tvalid_next = 1'b1;
                    state_next    = S_READY;
                end
            end
            default: state_next = S_READY;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_READY;
            cnt_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        if (state_reg == S_READY && s_tvalid) begin
            kind_reg <= s_kind;
            tail_reg <= s_tail;
        end
    end

    assign s_tready = state_reg == S_READY;
    assign m_tvalid = m_tvalid_reg;

endmodule
